[rtl/core/escu_pkg.sv]
// Shared types and constants for the escaped text unescaper.
// Depends on nothing; used by rtl/core/escaped_text_unescaper.sv and tb/sv/tb.sv.
`timescale 1ns / 1ps

package escu_pkg;

    // Width of the running position marks (16 to 64).
    localparam int MARK_W = 32;
    // Width of the mark fields on the ports.
    localparam int PORT_MARK_W = 32;

    typedef logic [MARK_W-1:0] mark_t;
    typedef logic [MARK_W:0]   mark_ext_t;

    typedef enum logic [1:0] {
        PH_PLAIN   = 2'd0,
        PH_LETTER  = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_SWALLOW = 2'd3
    } phase_t;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [31:0] CP_LF    = 32'h0000_000A;

    // Hex digit counts for each escape letter
    localparam logic [3:0] DIGITS_X = 4'd2;
    localparam logic [3:0] DIGITS_u = 4'd4;
    localparam logic [3:0] DIGITS_U = 4'd8;

    // UTF-8 range limits and lead/continuation marks
    localparam logic [31:0] CP_LIM1 = 32'h0000_0080;
    localparam logic [31:0] CP_LIM2 = 32'h0000_0800;
    localparam logic [31:0] CP_LIM3 = 32'h0001_0000;
    localparam logic [7:0]  LEAD2   = 8'hC0;
    localparam logic [7:0]  LEAD3   = 8'hE0;
    localparam logic [7:0]  LEAD4   = 8'hF0;
    localparam logic [7:0]  CONT    = 8'h80;

    // Output result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One accepted item's worth of results: up to four bytes and an end record.
    typedef struct packed {
        logic [3:0][7:0]        bytes;
        logic [2:0]             nbytes;
        logic                   has_end;
        logic                   status;
        logic [PORT_MARK_W-1:0] end_byte;
        logic [PORT_MARK_W-1:0] end_char;
        logic [PORT_MARK_W-1:0] end_line;
        logic [PORT_MARK_W-1:0] end_col;
    } rec_t;

endpackage

[rtl/core/escaped_text_unescaper.sv]
// Escaped text unescaper: hex escape decode, UTF-8 encode and position marks.
// An item's results are registered into the result buffer as its beat is taken.
// Throughput: one input beat per cycle while items yield at most one result and the
// output is not held; an item yielding n results is sent as n output beats, the two-record
// buffer takes one further item meanwhile, then the input stalls until it drains.
// Reset (rst_n low, async): escape state, marks and error cleared, buffer empty.
`timescale 1ns / 1ps

module escaped_text_unescaper (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] text_byte, [39:8] start_byte_offset, [71:40] start_char_offset,
    // [103:72] start_line, [135:104] start_column
    input  logic [135:0] s_axis_tdata,
    // [0] has_byte, [1] first_of_token
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] utf8_byte, [8] status, [40:9] end_byte_offset, [72:41] end_char_offset,
    // [104:73] end_line, [136:105] end_column, [143:137] zero
    output logic [143:0] m_axis_tdata,
    // [0] kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39)
            v = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46)
            v = {1'b0, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66)
            v = {1'b0, 4'(b - 8'h57)};
        else
            v = 5'h10;
        return v;
    endfunction

    function automatic escu_pkg::mark_t sat_inc(input escu_pkg::mark_t m,
                                                input logic [2:0] k);
        escu_pkg::mark_ext_t s;
        s = {1'b0, m} + escu_pkg::mark_ext_t'(k);
        return s[escu_pkg::MARK_W] ? '1 : s[escu_pkg::MARK_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic       in_accept;
    logic       has_byte;
    logic       first_tok;
    logic       last_tok;
    logic [7:0] text_byte;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign has_byte  = s_axis_tuser[0];
    assign first_tok = s_axis_tuser[1];
    assign last_tok  = s_axis_tlast;
    assign text_byte = s_axis_tdata[7:0];

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    escu_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       digits_reg, digits_next;
    logic [31:0]      acc_reg, acc_next;
    logic             err_reg, err_next;
    escu_pkg::mark_t  bytes_reg, bytes_next;
    escu_pkg::mark_t  chars_reg, chars_next;
    escu_pkg::mark_t  lines_reg, lines_next;
    escu_pkg::mark_t  cols_reg, cols_next;

    escu_pkg::phase_t ph_base, ph_b;
    logic [3:0]       dg_base, dg_b;
    logic [31:0]      acc_base, acc_b;
    logic             err_base, err_b;
    logic [4:0]       hv;
    logic             emit;
    logic [31:0]      cp;

    // Escape sequencing
    always_comb
    begin
        ph_base  = first_tok ? escu_pkg::PH_PLAIN : phase_reg;
        dg_base  = first_tok ? 4'd0 : digits_reg;
        acc_base = first_tok ? 32'd0 : acc_reg;
        err_base = first_tok ? 1'b0 : err_reg;
        ph_b     = ph_base;
        dg_b     = dg_base;
        acc_b    = acc_base;
        err_b    = err_base;
        hv       = hex_val(text_byte);
        emit     = 1'b0;
        cp       = 32'd0;
        if (has_byte)
        begin
            case (ph_base)
                escu_pkg::PH_PLAIN:
                begin
                    if (text_byte == escu_pkg::CH_BSLASH)
                        ph_b = escu_pkg::PH_LETTER;
                    else
                    begin
                        emit = 1'b1;
                        cp   = {24'd0, text_byte};
                    end
                end
                escu_pkg::PH_LETTER:
                begin
                    if (text_byte == escu_pkg::CH_LOW_X || text_byte == escu_pkg::CH_LOW_U
                        || text_byte == escu_pkg::CH_UP_U)
                    begin
                        dg_b  = (text_byte == escu_pkg::CH_LOW_X) ? escu_pkg::DIGITS_X :
                                (text_byte == escu_pkg::CH_LOW_U) ? escu_pkg::DIGITS_u :
                                                                    escu_pkg::DIGITS_U;
                        acc_b = 32'd0;
                        ph_b  = escu_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        err_b = 1'b1;
                        ph_b  = escu_pkg::PH_SWALLOW;
                        dg_b  = 4'd0;
                        acc_b = 32'd0;
                    end
                end
                escu_pkg::PH_DIGITS:
                begin
                    if (hv[4])
                    begin
                        err_b = 1'b1;
                        ph_b  = escu_pkg::PH_SWALLOW;
                        dg_b  = 4'd0;
                        acc_b = 32'd0;
                    end
                    else
                    begin
                        acc_b = {acc_base[27:0], hv[3:0]};
                        dg_b  = dg_base - 4'd1;
                        if (dg_b == 4'd0)
                        begin
                            ph_b  = escu_pkg::PH_PLAIN;
                            emit  = 1'b1;
                            cp    = acc_b;
                            acc_b = 32'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // UTF-8 encoding, mark update and end record
    escu_pkg::rec_t  rec_in;
    logic [2:0]      rec_total;
    escu_pkg::mark_t mb_base, mc_base, ml_base, mk_base;

    always_comb
    begin
        mb_base = first_tok ? escu_pkg::mark_t'(s_axis_tdata[39:8])   : bytes_reg;
        mc_base = first_tok ? escu_pkg::mark_t'(s_axis_tdata[71:40])  : chars_reg;
        ml_base = first_tok ? escu_pkg::mark_t'(s_axis_tdata[103:72]) : lines_reg;
        mk_base = first_tok ? escu_pkg::mark_t'(s_axis_tdata[135:104]) : cols_reg;

        rec_in = '0;
        if (emit)
        begin
            if (cp < escu_pkg::CP_LIM1)
            begin
                rec_in.bytes[0] = cp[7:0];
                rec_in.nbytes   = 3'd1;
            end
            else if (cp < escu_pkg::CP_LIM2)
            begin
                rec_in.bytes[0] = escu_pkg::LEAD2 | {3'd0, cp[10:6]};
                rec_in.bytes[1] = escu_pkg::CONT | {2'd0, cp[5:0]};
                rec_in.nbytes   = 3'd2;
            end
            else if (cp < escu_pkg::CP_LIM3)
            begin
                rec_in.bytes[0] = escu_pkg::LEAD3 | {4'd0, cp[15:12]};
                rec_in.bytes[1] = escu_pkg::CONT | {2'd0, cp[11:6]};
                rec_in.bytes[2] = escu_pkg::CONT | {2'd0, cp[5:0]};
                rec_in.nbytes   = 3'd3;
            end
            else
            begin
                // lead keeps only the low byte of F0 | cp >> 18
                rec_in.bytes[0] = escu_pkg::LEAD4 | cp[25:18];
                rec_in.bytes[1] = escu_pkg::CONT | {2'd0, cp[17:12]};
                rec_in.bytes[2] = escu_pkg::CONT | {2'd0, cp[11:6]};
                rec_in.bytes[3] = escu_pkg::CONT | {2'd0, cp[5:0]};
                rec_in.nbytes   = 3'd4;
            end
        end

        bytes_next = mb_base;
        chars_next = mc_base;
        lines_next = ml_base;
        cols_next  = mk_base;
        if (emit)
        begin
            bytes_next = sat_inc(mb_base, rec_in.nbytes);
            chars_next = sat_inc(mc_base, 3'd1);
            if (cp == escu_pkg::CP_LF)
            begin
                lines_next = sat_inc(ml_base, 3'd1);
                cols_next  = '0;
            end
            else
                cols_next = sat_inc(mk_base, 3'd1);
        end

        phase_next  = ph_b;
        digits_next = dg_b;
        acc_next    = acc_b;
        err_next    = err_b;
        if (last_tok)
        begin
            rec_in.has_end  = 1'b1;
            // error status, also set when the token ended inside an escape
            rec_in.status   = err_b || ph_b == escu_pkg::PH_LETTER
                              || ph_b == escu_pkg::PH_DIGITS;
            rec_in.end_byte = escu_pkg::PORT_MARK_W'(bytes_next);
            rec_in.end_char = escu_pkg::PORT_MARK_W'(chars_next);
            rec_in.end_line = escu_pkg::PORT_MARK_W'(lines_next);
            rec_in.end_col  = escu_pkg::PORT_MARK_W'(cols_next);
            phase_next      = escu_pkg::PH_PLAIN;
            digits_next     = 4'd0;
            acc_next        = 32'd0;
            err_next        = 1'b0;
        end
        rec_total = rec_in.nbytes + {2'd0, rec_in.has_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= escu_pkg::PH_PLAIN;
            digits_reg <= 4'd0;
            acc_reg    <= 32'd0;
            err_reg    <= 1'b0;
            bytes_reg  <= '0;
            chars_reg  <= '0;
            lines_reg  <= '0;
            cols_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            bytes_reg  <= bytes_next;
            chars_reg  <= chars_next;
            lines_reg  <= lines_next;
            cols_reg   <= cols_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-record result buffer, drained one beat per cycle while the receiver is ready
    // ------------------------------------------------------------------
    escu_pkg::rec_t rec_q [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [2:0] idx_reg, idx_next;
    logic       push, pop, out_accept;
    escu_pkg::rec_t head;
    logic [2:0] head_total;
    logic       head_last;
    logic       is_end;

    assign s_axis_tready = (count_reg != 2'd2);
    assign head          = rec_q[rd_ptr_reg];
    assign head_total    = head.nbytes + {2'd0, head.has_end};
    assign head_last     = (idx_reg == head_total - 3'd1);
    assign is_end        = (idx_reg == head.nbytes);
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign push          = in_accept && (rec_total != 3'd0);
    assign pop           = out_accept && head_last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        idx_next    = idx_reg;
        if (pop)
            idx_next = 3'd0;
        else if (out_accept)
            idx_next = idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            rec_q[wr_ptr_reg] <= rec_in;
    end

    always_comb
    begin
        m_axis_tvalid = (count_reg != 2'd0);
        m_axis_tuser  = is_end ? escu_pkg::KIND_END : escu_pkg::KIND_BYTE;
        m_axis_tlast  = head_last;
        m_axis_tdata  = '0;
        if (is_end)
        begin
            m_axis_tdata[8]       = head.status;
            m_axis_tdata[40:9]    = head.end_byte;
            m_axis_tdata[72:41]   = head.end_char;
            m_axis_tdata[104:73]  = head.end_line;
            m_axis_tdata[136:105] = head.end_col;
        end
        else
            m_axis_tdata[7:0] = head.bytes[idx_reg[1:0]];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_idx_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (idx_reg < head_total))
        else $error("result index beyond record");

    a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 3'd0))
        else $error("result index not cleared after record drained");

    a_byte_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == escu_pkg::KIND_BYTE)
            |-> (m_axis_tdata[143:8] == '0))
        else $error("byte beat carries end record fields");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for escaped_text_unescaper: escape decoding, UTF-8 output,
// end-of-token marks and status, checked beat by beat against a built-in predictor.
// Depends on rtl/core/escu_pkg.sv and rtl/core/escaped_text_unescaper.sv.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 85;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PCT = 23;

    typedef struct {
        bit         has;
        logic [7:0] ch;
        bit         first;
        bit         last;
        logic [31:0] mb;
        logic [31:0] mc;
        logic [31:0] ml;
        logic [31:0] mcol;
    } text_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data8;
        logic        status;
        logic [31:0] e_byte;
        logic [31:0] e_char;
        logic [31:0] e_line;
        logic [31:0] e_col;
        logic        last;
    } out_beat_t;

    class unescape_scoreboard;
        escu_pkg::phase_t phase;
        logic [3:0]       digits_left;
        logic [31:0]      acc;
        escu_pkg::mark_t  m_byte;
        escu_pkg::mark_t  m_char;
        escu_pkg::mark_t  m_line;
        escu_pkg::mark_t  m_col;
        bit               err;
        out_beat_t        expected_out[$];
        out_beat_t        run[$];
        int               errors;
        int               beats;

        function new();
            phase = escu_pkg::PH_PLAIN;
            digits_left = '0;
            acc = '0;
            m_byte = '0;
            m_char = '0;
            m_line = '0;
            m_col = '0;
            err = 0;
            errors = 0;
            beats = 0;
        endfunction

        function escu_pkg::mark_t sat_inc(escu_pkg::mark_t m, int unsigned k);
            escu_pkg::mark_ext_t s;
            s = {1'b0, m} + escu_pkg::mark_ext_t'(k);
            return s[escu_pkg::MARK_W] ? {escu_pkg::MARK_W{1'b1}}
                                       : s[escu_pkg::MARK_W-1:0];
        endfunction

        function void put(logic kind, logic [7:0] d);
            out_beat_t o;
            o = '0;
            o.kind = kind;
            o.data8 = d;
            run.push_back(o);
        endfunction

        function void encode_cp(logic [31:0] cp);
            int unsigned n;
            if (cp < escu_pkg::CP_LIM1) begin
                put(escu_pkg::KIND_BYTE, cp[7:0]);
                n = 1;
            end
            else if (cp < escu_pkg::CP_LIM2) begin
                put(escu_pkg::KIND_BYTE, escu_pkg::LEAD2 | 8'(cp >> 6));
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[5:0]});
                n = 2;
            end
            else if (cp < escu_pkg::CP_LIM3) begin
                put(escu_pkg::KIND_BYTE, escu_pkg::LEAD3 | 8'(cp >> 12));
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[11:6]});
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[5:0]});
                n = 3;
            end
            else begin
                // lead byte keeps only its low 8 bits for huge values
                put(escu_pkg::KIND_BYTE, escu_pkg::LEAD4 | 8'(cp >> 18));
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[17:12]});
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[11:6]});
                put(escu_pkg::KIND_BYTE, escu_pkg::CONT | {2'b00, cp[5:0]});
                n = 4;
            end
            m_byte = sat_inc(m_byte, n);
            m_char = sat_inc(m_char, 1);
            if (cp == escu_pkg::CP_LF) begin
                m_line = sat_inc(m_line, 1);
                m_col = '0;
            end
            else begin
                m_col = sat_inc(m_col, 1);
            end
        endfunction

        function void go_swallow();
            err = 1;
            phase = escu_pkg::PH_SWALLOW;
            digits_left = '0;
            acc = '0;
        endfunction

        function int nibble_of(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return int'(b) - int'("0");
            if (b >= "A" && b <= "F")
                return int'(b) - int'("A") + 10;
            if (b >= "a" && b <= "f")
                return int'(b) - int'("a") + 10;
            return -1;
        endfunction

        function void take(logic [7:0] b);
            int v;
            case (phase)
                escu_pkg::PH_PLAIN:
                    if (b == escu_pkg::CH_BSLASH)
                        phase = escu_pkg::PH_LETTER;
                    else
                        encode_cp({24'b0, b});
                escu_pkg::PH_LETTER:
                    if (b == escu_pkg::CH_LOW_X || b == escu_pkg::CH_LOW_U
                        || b == escu_pkg::CH_UP_U) begin
                        digits_left = (b == escu_pkg::CH_LOW_X) ? escu_pkg::DIGITS_X
                                    : (b == escu_pkg::CH_LOW_U) ? escu_pkg::DIGITS_u
                                                                : escu_pkg::DIGITS_U;
                        acc = '0;
                        phase = escu_pkg::PH_DIGITS;
                    end
                    else begin
                        go_swallow();
                    end
                escu_pkg::PH_DIGITS: begin
                    v = nibble_of(b);
                    if (v < 0) begin
                        go_swallow();
                    end
                    else begin
                        acc = {acc[27:0], 4'(v)};
                        digits_left = digits_left - 4'd1;
                        if (digits_left == 0) begin
                            phase = escu_pkg::PH_PLAIN;
                            encode_cp(acc);
                            acc = '0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_item(text_item_t it);
            out_beat_t o;
            run.delete();
            if (it.first) begin
                m_byte = escu_pkg::mark_t'(it.mb);
                m_char = escu_pkg::mark_t'(it.mc);
                m_line = escu_pkg::mark_t'(it.ml);
                m_col = escu_pkg::mark_t'(it.mcol);
                phase = escu_pkg::PH_PLAIN;
                digits_left = '0;
                acc = '0;
                err = 0;
            end
            if (it.has)
                take(it.ch);
            if (it.last) begin
                // token cut short inside an escape
                if (phase == escu_pkg::PH_LETTER || phase == escu_pkg::PH_DIGITS)
                    err = 1;
                o = '0;
                o.kind = escu_pkg::KIND_END;
                o.status = err;
                o.e_byte = escu_pkg::PORT_MARK_W'(m_byte);
                o.e_char = escu_pkg::PORT_MARK_W'(m_char);
                o.e_line = escu_pkg::PORT_MARK_W'(m_line);
                o.e_col = escu_pkg::PORT_MARK_W'(m_col);
                run.push_back(o);
                phase = escu_pkg::PH_PLAIN;
                digits_left = '0;
                acc = '0;
                err = 0;
            end
            if (run.size() > 0)
                run[run.size()-1].last = 1'b1;
            foreach (run[i])
                expected_out.push_back(run[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ERROR: %s", $realtime, msg);
        endtask

        task check_result(out_beat_t got);
            out_beat_t e;
            beats++;
            if (expected_out.size() == 0) begin
                report($sformatf("beat %0d arrived with nothing expected", beats));
            end
            else begin
                e = expected_out.pop_front();
                if (got !== e)
                    report($sformatf({"beat %0d: got k%b d%h s%b %h/%h/%h/%h l%b,",
                                      " expected k%b d%h s%b %h/%h/%h/%h l%b"}, beats,
                                     got.kind, got.data8, got.status, got.e_byte,
                                     got.e_char, got.e_line, got.e_col, got.last,
                                     e.kind, e.data8, e.status, e.e_byte,
                                     e.e_char, e.e_line, e.e_col, e.last));
            end
        endtask

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    unescape_scoreboard sb;
    text_item_t         stim_q[$];
    out_beat_t          seen_beat;
    bit                 idle_on;
    bit                 hold_req;
    int                 hold_left;
    int                 random_items;
    int                 cycles;

    escaped_text_unescaper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_beat.kind = m_axis_tuser;
            seen_beat.data8 = m_axis_tdata[7:0];
            seen_beat.status = m_axis_tdata[8];
            seen_beat.e_byte = m_axis_tdata[40:9];
            seen_beat.e_char = m_axis_tdata[72:41];
            seen_beat.e_line = m_axis_tdata[104:73];
            seen_beat.e_col = m_axis_tdata[136:105];
            seen_beat.last = m_axis_tlast;
            sb.check_result(seen_beat);
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic bit is_hex_digit(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10)
            return 8'("0") + 8'(v);
        return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [31:0] pick_mark();
        case ($urandom_range(9))
            0, 1: return 32'hFFFF_FFFF - 32'($urandom_range(5));
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(bit has, logic [7:0] ch, bit first, bit last,
                             logic [31:0] mb, logic [31:0] mc, logic [31:0] ml,
                             logic [31:0] mcol);
        text_item_t it;
        it.has = has;
        it.ch = ch;
        it.first = first;
        it.last = last;
        it.mb = mb;
        it.mc = mc;
        it.ml = ml;
        it.mcol = mcol;
        stim_q.push_back(it);
    endtask

    task automatic build_directed();
        logic [7:0] big_u[$];
        // plain byte before any token start: runs against the reset marks
        push_item(1, "A", 0, 0, '0, '0, '0, '0);
        // raw high byte on marks close to saturation
        push_item(1, 8'hFF, 1, 0, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                  32'hFFFF_FFFC);
        big_u = '{escu_pkg::CH_BSLASH, escu_pkg::CH_UP_U, "F", "f", "F", "F", "F", "F",
                  "F", "F"};
        foreach (big_u[i])
            push_item(1, big_u[i], 0, 0, '0, '0, '0, '0);
        // \x0a: line feed through an escape
        push_item(1, escu_pkg::CH_BSLASH, 0, 0, '0, '0, '0, '0);
        push_item(1, escu_pkg::CH_LOW_X, 0, 0, '0, '0, '0, '0);
        push_item(1, "0", 0, 0, '0, '0, '0, '0);
        push_item(1, "a", 0, 0, '0, '0, '0, '0);
        push_item(0, 8'h00, 0, 1, '0, '0, '0, '0);
        // bad escape letter, rest swallowed
        push_item(1, escu_pkg::CH_BSLASH, 1, 0, '0, '0, '0, '0);
        push_item(1, "q", 0, 0, '0, '0, '0, '0);
        push_item(1, "Z", 0, 1, '0, '0, '0, '0);
        // truncated after the backslash
        push_item(1, escu_pkg::CH_BSLASH, 1, 1, 32'h1234_5678, 32'h8765_4321,
                  32'hA5A5_A5A5, 32'h5A5A_5A5A);
        // empty token
        push_item(0, 8'h00, 1, 1, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0);
        // bad hex digit
        push_item(1, escu_pkg::CH_BSLASH, 1, 0, 32'd100, 32'd50, 32'd7, 32'd3);
        push_item(1, escu_pkg::CH_LOW_X, 0, 0, '0, '0, '0, '0);
        push_item(1, "g", 0, 1, '0, '0, '0, '0);
    endtask

    task automatic add_token();
        logic [7:0]  tok[$];
        bit          with_first;
        bit          end_on_byte;
        int          pieces;
        int          r;
        int          nd;
        logic [7:0]  b;
        logic [31:0] mb;
        logic [31:0] mc;
        logic [31:0] ml;
        logic [31:0] mcol;
        pieces = $urandom_range(0, 5);
        for (int p = 0; p < pieces; p++)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                b = 8'($urandom);
                if (b == escu_pkg::CH_BSLASH)
                    b = 8'h5B;
                tok.push_back(b);
            end
            else if (r < 52)
            begin
                tok.push_back(8'h0A);
            end
            else if (r < 82)
            begin
                tok.push_back(escu_pkg::CH_BSLASH);
                case ($urandom_range(2))
                    0:
                    begin
                        tok.push_back(escu_pkg::CH_LOW_X);
                        nd = 2;
                    end
                    1:
                    begin
                        tok.push_back(escu_pkg::CH_LOW_U);
                        nd = 4;
                    end
                    default:
                    begin
                        tok.push_back(escu_pkg::CH_UP_U);
                        nd = 8;
                    end
                endcase
                for (int d = 0; d < nd; d++)
                begin
                    // \U often kept within the Unicode range
                    if (nd == 8 && d < 3 && $urandom_range(1))
                        tok.push_back("0");
                    else
                        tok.push_back(hex_char(4'($urandom), 1'($urandom_range(1))));
                end
            end
            else if (r < 91)
            begin
                tok.push_back(escu_pkg::CH_BSLASH);
                b = 8'($urandom);
                if (b == escu_pkg::CH_LOW_X || b == escu_pkg::CH_LOW_U
                    || b == escu_pkg::CH_UP_U)
                    b = "q";
                tok.push_back(b);
            end
            else
            begin
                tok.push_back(escu_pkg::CH_BSLASH);
                tok.push_back($urandom_range(1) ? escu_pkg::CH_LOW_X : escu_pkg::CH_LOW_U);
                if ($urandom_range(1))
                    tok.push_back(hex_char(4'($urandom), 1'($urandom_range(1))));
                b = 8'($urandom);
                if (is_hex_digit(b))
                    b = "z";
                tok.push_back(b);
            end
        end
        // truncated escape at the end of the token
        if ($urandom_range(99) < 10)
        begin
            tok.push_back(escu_pkg::CH_BSLASH);
            if ($urandom_range(1))
            begin
                tok.push_back(escu_pkg::CH_LOW_U);
                tok.push_back(hex_char(4'($urandom), 1'($urandom_range(1))));
            end
        end
        with_first = $urandom_range(99) >= 15;
        end_on_byte = tok.size() > 0 && $urandom_range(1);
        mb = pick_mark();
        mc = pick_mark();
        ml = pick_mark();
        mcol = pick_mark();
        if ($urandom_range(99) < 8)
            push_item(0, 8'($urandom), 0, 0, $urandom, $urandom, $urandom, $urandom);
        foreach (tok[i])
        begin
            push_item(1, tok[i], with_first && i == 0,
                      end_on_byte && i == tok.size() - 1, mb, mc, ml, mcol);
            random_items++;
        end
        if (!end_on_byte)
        begin
            push_item(0, 8'($urandom), with_first && tok.size() == 0, 1, mb, mc, ml, mcol);
            random_items++;
        end
    endtask

    // entered and left just after a falling edge; tvalid stays high on exit
    task automatic send_item(text_item_t it);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata = {it.mcol, it.ml, it.mc, it.mb, it.ch};
        s_axis_tuser = {it.first, it.has};
        s_axis_tlast = it.last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    initial
    begin
        int n_directed;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        idle_on = 1;
        hold_req = 0;
        cycles = 0;
        random_items = 0;
        sb = new();
        build_directed();
        n_directed = stim_q.size();
        while (random_items < RANDOM_ITEMS)
            add_token();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (stim_q[i])
        begin
            if (i == n_directed + 30)
                hold_req = 1;
            // quiet stretch: neither side idles
            idle_on = !(i >= n_directed + 45 && i < n_directed + 75);
            if (i == n_directed + 80)
            begin
                s_axis_tvalid = 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            send_item(stim_q[i]);
        end
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/core/escu_pkg.sv
rtl/core/escaped_text_unescaper.sv
tb/sv/tb.sv
